>>> src/linear_scan_key_value_table_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the linear scan key/value table
// Shared by the modules that carry concurrent checks; each expects clk and
// rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LINEAR_SCAN_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define LINEAR_SCAN_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define LSKVT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lskvt same-cycle check failed");

// next-cycle implication
`define LSKVT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lskvt next-cycle check failed");

`endif

>>> src/lskvt_pkg.sv
// ---------------------------------------------------------------------------
// lskvt_pkg
// Operation codes and the command/status bundles between controller and
// datapath.
// ---------------------------------------------------------------------------
package lskvt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic load;       // capture input word, clear index and result flags
    logic rd;         // read both stores
    logic rd_next;    // read at index + 1 instead of index
    logic inc_idx;
    logic wr_val;     // overwrite value at index
    logic append;     // write pair at slot count, bump count
    logic shift_wr;   // write read-back pair at index
    logic dec_count;
    logic set_found;
    logic set_drop;
    logic set_vout;
    logic emit;       // load output register
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic at_end;     // index equals count
    logic last;       // index + 1 equals count
    logic full;
    logic match;      // read-back key equals held key
    logic out_free;   // output register may be loaded
  } sts_t;

endpackage

>>> src/linear_scan_key_value_table_top.sv
// ---------------------------------------------------------------------------
// linear_scan_key_value_table_top
// Packed key/value table with linear search: insert/update, lookup and
// remove with shift-down.
//
// Input channel in_valid/in_ready carries one word {op, key, value}; the
// result channel out_valid/out_ready returns exactly one word per input.
// One operation is in flight at a time; in_ready is high whenever the
// sequencer is idle, even while the previous result waits in the output
// register.
// Each slot scanned costs a read of the key/value RAMs, then a compare;
// the scan ends at a hit on lookup or update, or after the last slot on
// a miss. A remove that hits then moves each later entry down one slot (a
// read, then a write) and lowers the count. in_ready rises as the result
// loads. The longest operation, set by the single read port of the stores,
// is a miss in, or a remove from, a full table.
// Reset empties the table at once (count to zero); the stores are not
// cleared, as no slot at or above the count is ever read.
// When the receiver stalls, the finished result holds in the output
// register; the next one holds in the result state, with in_ready low,
// until it drains.
// ---------------------------------------------------------------------------
module linear_scan_key_value_table_top #(
  parameter int ENTRIES    = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [31:0] out_value_out,
  output logic        out_dropped,
  output logic        out_is_empty,
  output logic [8:0]  out_entry_count,
  output logic [31:0] out_first_key
);

  lskvt_pkg::cmd_t cmd;
  lskvt_pkg::sts_t sts;

  lskvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lskvt_dpath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_value_out   (out_value_out),
    .out_dropped     (out_dropped),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count),
    .out_first_key   (out_first_key),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

>>> src/lskvt_ram.sv
// ---------------------------------------------------------------------------
// lskvt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module lskvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/lskvt_ctrl.sv
// ---------------------------------------------------------------------------
// lskvt_ctrl
// Sequencer for scan, update, append and shift-down of the table.
// ---------------------------------------------------------------------------
`include "linear_scan_key_value_table_top_assert.svh"

module lskvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lskvt_pkg::sts_t   sts,
  output lskvt_pkg::cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN_RD  = 6'b000010,
    ST_SCAN_CMP = 6'b000100,
    ST_SHIFT_RD = 6'b001000,
    ST_SHIFT_WR = 6'b010000,
    ST_RESP     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts.op == lskvt_pkg::OP_NOP) begin
          state_nxt = ST_RESP;
        end else if (sts.at_end) begin
          // no match: append on insert, or flag the drop when full
          if (sts.op == lskvt_pkg::OP_INSERT) begin
            if (sts.full) begin
              cmd.set_drop = 1'b1;
            end else begin
              cmd.append = 1'b1;
            end
          end
          state_nxt = ST_RESP;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (sts.match) begin
          cmd.set_found = 1'b1;
          case (sts.op)
            lskvt_pkg::OP_INSERT: begin
              cmd.wr_val = 1'b1;
              state_nxt  = ST_RESP;
            end
            lskvt_pkg::OP_LOOKUP: begin
              cmd.set_vout = 1'b1;
              state_nxt    = ST_RESP;
            end
            lskvt_pkg::OP_REMOVE: begin
              state_nxt = ST_SHIFT_RD;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (sts.last) begin
          cmd.dec_count = 1'b1;
          state_nxt     = ST_RESP;
        end else begin
          cmd.rd      = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.inc_idx  = 1'b1;
        state_nxt    = ST_SHIFT_RD;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LSKVT_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE)
  `LSKVT_ASSERT_IMP(a_emit_only_free, cmd.emit, sts.out_free)
  `LSKVT_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_r))

endmodule

>>> src/lskvt_dpath.sv
// ---------------------------------------------------------------------------
// lskvt_dpath
// Key and value stores, fill count, scan index, slot-0 key copy and the
// output register.
// ---------------------------------------------------------------------------
`include "linear_scan_key_value_table_top_assert.svh"

module lskvt_dpath #(
  parameter int ENTRIES    = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_op,
  input  logic [31:0]       in_key,
  input  logic [31:0]       in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [31:0]       out_value_out,
  output logic              out_dropped,
  output logic              out_is_empty,
  output logic [8:0]        out_entry_count,
  output logic [31:0]       out_first_key,
  input  lskvt_pkg::cmd_t   cmd,
  output lskvt_pkg::sts_t   sts
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  lskvt_pkg::op_t        op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]         idx_r, idx_nxt, idx_plus;
  logic [CW-1:0]         count_r, count_nxt;
  logic [KEY_BITS-1:0]   first_key_r, first_key_nxt;
  logic                  found_r, found_nxt;
  logic                  drop_r, drop_nxt;
  logic [31:0]           vout_r, vout_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_dropped_r, out_is_empty_r;
  logic [31:0]           out_value_r, out_first_key_r;
  logic [8:0]            out_count_r;

  logic [KEY_BITS+31:0]   key_in_ext;
  logic [VALUE_BITS+31:0] val_in_ext;
  logic [VALUE_BITS+31:0] val_rd_ext;
  logic [KEY_BITS+31:0]   first_key_ext;
  logic [CW+8:0]          count_ext;

  logic                  key_we, val_we, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [KEY_BITS-1:0]   key_wdata, key_rd;
  logic [VALUE_BITS-1:0] val_wdata, val_rd;

  assign key_in_ext    = {{KEY_BITS{1'b0}}, in_key};
  assign val_in_ext    = {{VALUE_BITS{1'b0}}, in_value};
  assign val_rd_ext    = {{32{1'b0}}, val_rd};
  assign first_key_ext = {{32{1'b0}}, first_key_r};
  assign count_ext     = {9'd0, count_r};
  assign idx_plus      = idx_r + CW'(1);

  // store ports
  assign key_we    = cmd.append | cmd.shift_wr;
  assign val_we    = cmd.append | cmd.shift_wr | cmd.wr_val;
  assign wr_addr   = cmd.append ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign key_wdata = cmd.append ? key_r : key_rd;
  assign val_wdata = cmd.shift_wr ? val_rd : val_r;
  assign rd_en     = cmd.rd;
  assign rd_addr   = cmd.rd_next ? idx_plus[AW-1:0] : idx_r[AW-1:0];

  lskvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (wr_addr),
    .wr_data (key_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  lskvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (wr_addr),
    .wr_data (val_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (val_rd)
  );

  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    first_key_nxt = first_key_r;
    found_nxt     = found_r;
    drop_nxt      = drop_r;
    vout_nxt      = vout_r;

    if (cmd.load) begin
      op_nxt    = lskvt_pkg::op_t'(in_op);
      key_nxt   = key_in_ext[KEY_BITS-1:0];
      val_nxt   = val_in_ext[VALUE_BITS-1:0];
      idx_nxt   = '0;
      found_nxt = 1'b0;
      drop_nxt  = 1'b0;
      vout_nxt  = '0;
    end
    if (cmd.inc_idx) begin
      idx_nxt = idx_plus;
    end
    if (cmd.append) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
    // keep a copy of slot 0 so the status needs no extra read
    if (key_we && (wr_addr == '0)) begin
      first_key_nxt = key_wdata;
    end
    if (cmd.set_found) begin
      found_nxt = 1'b1;
    end
    if (cmd.set_drop) begin
      drop_nxt = 1'b1;
    end
    if (cmd.set_vout) begin
      vout_nxt = val_rd_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    first_key_r <= first_key_nxt;
    found_r     <= found_nxt;
    drop_r      <= drop_nxt;
    vout_r      <= vout_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r     <= found_r;
      out_value_r     <= vout_r;
      out_dropped_r   <= drop_r;
      out_is_empty_r  <= (count_r == '0);
      out_count_r     <= count_ext[8:0];
      out_first_key_r <= (count_r == '0) ? 32'd0 : first_key_ext[31:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_value_out   = out_value_r;
  assign out_dropped     = out_dropped_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_entry_count = out_count_r;
  assign out_first_key   = out_first_key_r;

  assign sts.op       = op_r;
  assign sts.at_end   = (idx_r == count_r);
  assign sts.last     = (idx_plus == count_r);
  assign sts.full     = (count_r == CW'(ENTRIES));
  assign sts.match    = (key_rd == key_r);
  assign sts.out_free = !out_valid_r || out_ready;

  `LSKVT_ASSERT_IMP(a_count_bounded, 1'b1, count_r <= CW'(ENTRIES))
  `LSKVT_ASSERT_IMP(a_append_not_full, cmd.append, count_r != CW'(ENTRIES))
  `LSKVT_ASSERT_IMP(a_shrink_not_empty, cmd.dec_count, count_r != '0)

endmodule
